>>> hdl/tms_pkg.sv
// Shared constants, table word layout and state types for the totient/Moebius sieve sums.
package tms_pkg;

	// Table range and derived widths
	localparam int unsigned MAX_N = 131072;
	localparam int unsigned NW    = $clog2(MAX_N + 1);  // index / query value width
	localparam int unsigned PHI_W = $clog2(MAX_N);      // stored totient width
	localparam int unsigned QW    = 18;                 // query_n port width
	localparam int unsigned CP_W  = 35;                 // coprime_pairs width
	localparam int unsigned GS_W  = 48;                 // gcd_sum width

	// Moebius codes, two's complement in two bits
	localparam logic [1:0] MU_ZERO = 2'b00;
	localparam logic [1:0] MU_POS  = 2'b01;
	localparam logic [1:0] MU_NEG  = 2'b11;

	typedef struct packed {
		logic             prime;
		logic [1:0]       mu;
		logic [PHI_W-1:0] phi;
	} tbl_word_t;

	typedef struct packed {
		logic          en;
		logic [NW-1:0] addr;
	} ram_rd_t;

	typedef struct packed {
		logic          en;
		logic [NW-1:0] addr;
		tbl_word_t     data;
	} ram_wr_t;

	typedef enum logic [2:0] {
		SV_IDLE,
		SV_INIT,
		SV_SCAN_RD,
		SV_SCAN_CHK,
		SV_PASS
	} sieve_state_t;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_BUILD,
		TS_LAUNCH,
		TS_SUM
	} top_state_t;

endpackage

>>> hdl/tms_table_ram.sv
// Table memory: one write port, one registered read port, same-edge write forwarding.
module tms_table_ram import tms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ram_rd_t   rd,
	input  ram_wr_t   wr,
	output tbl_word_t rd_data
);

	tbl_word_t mem [0:MAX_N];
	tbl_word_t rdata_q;
	tbl_word_t fwd_data_q;
	logic      fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
		fwd_data_q <= wr.data;
	end

	// flag a read that lands on the entry written at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= rd.en && wr.en && (rd.addr == wr.addr);
		end
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : rdata_q;

endmodule

>>> hdl/tms_sieve.sv
// Table builder: init sweep, prime scan and one multiple-walk pass per prime.
module tms_sieve import tms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      go,
	input  tbl_word_t rd_data,
	output ram_rd_t   rd,
	output ram_wr_t   wr,
	output logic      built
);

	localparam int unsigned MW = PHI_W + NW;

	sieve_state_t   state_q, state_d;
	logic           built_q;
	logic [NW-1:0]  p_q;
	logic [NW-1:0]  j_q;
	logic [NW:0]    m_q;
	logic [NW-1:0]  c_q;

	logic           vld_s1;
	logic [NW-1:0]  m_s1;
	logic [NW-1:0]  fac_s1;
	logic           div_s1;
	logic           first_s1;

	logic [NW:0]    m_nxt;
	logic           pass_last;
	logic [NW-1:0]  c_inc;
	logic [NW-1:0]  c_nxt;
	logic           p_at_max;
	logic [MW-1:0]  phi_prod;
	logic [1:0]     mu_new;

	assign m_nxt     = m_q + (NW + 1)'(p_q);
	assign pass_last = m_nxt > (NW + 1)'(MAX_N);
	assign c_inc     = c_q + NW'(1);
	assign c_nxt     = (c_inc == p_q) ? '0 : c_inc;
	assign p_at_max  = (p_q == NW'(MAX_N));

	// phi(j*p) = phi(j) * p when p divides j, else phi(j) * (p - 1)
	assign phi_prod = MW'(rd_data.phi) * MW'(fac_s1);

	always_comb begin
		case (rd_data.mu)
			MU_POS:  mu_new = MU_NEG;
			MU_NEG:  mu_new = MU_POS;
			default: mu_new = MU_ZERO;
		endcase
		if (div_s1) begin
			mu_new = MU_ZERO;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SV_IDLE: begin
				if (go && !built_q) begin
					state_d = SV_INIT;
				end
			end
			SV_INIT: begin
				if (p_at_max) begin
					state_d = SV_SCAN_RD;
				end
			end
			SV_SCAN_RD: begin
				state_d = SV_SCAN_CHK;
			end
			SV_SCAN_CHK: begin
				if (rd_data.prime) begin
					state_d = SV_PASS;
				end else if (p_at_max) begin
					state_d = SV_IDLE;
				end else begin
					state_d = SV_SCAN_RD;
				end
			end
			SV_PASS: begin
				if (pass_last) begin
					state_d = p_at_max ? SV_IDLE : SV_SCAN_RD;
				end
			end
			default: begin
				state_d = SV_IDLE;
			end
		endcase
	end

	// memory port drive
	always_comb begin
		rd.en   = (state_q == SV_SCAN_RD) || (state_q == SV_PASS);
		rd.addr = (state_q == SV_SCAN_RD) ? p_q : j_q;

		wr.en   = 1'b0;
		wr.addr = m_s1;
		wr.data = '{prime: first_s1, mu: mu_new, phi: phi_prod[PHI_W-1:0]};
		if (vld_s1) begin
			wr.en = 1'b1;
		end else if (state_q == SV_INIT) begin
			wr.en   = 1'b1;
			wr.addr = p_q;
			// entries above half range only matter once a pass rewrites them
			if (p_q == '0) begin
				wr.data = '{prime: 1'b0, mu: MU_ZERO, phi: '0};
			end else if (p_q == NW'(1)) begin
				wr.data = '{prime: 1'b0, mu: MU_POS, phi: PHI_W'(1)};
			end else begin
				wr.data = '{prime: 1'b1, mu: MU_POS, phi: p_q[PHI_W-1:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SV_IDLE;
			built_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == SV_PASS);
			if ((state_q != SV_IDLE) && (state_d == SV_IDLE)) begin
				built_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		m_s1     <= m_q[NW-1:0];
		fac_s1   <= (c_q == '0) ? p_q : (p_q - NW'(1));
		div_s1   <= (c_q == '0);
		first_s1 <= (j_q == NW'(1));
		case (state_q)
			SV_IDLE: begin
				p_q <= '0;
			end
			SV_INIT: begin
				p_q <= p_at_max ? NW'(2) : (p_q + NW'(1));
			end
			SV_SCAN_CHK: begin
				if (rd_data.prime) begin
					j_q <= NW'(1);
					m_q <= (NW + 1)'(p_q);
					c_q <= NW'(1);
				end else if (!p_at_max) begin
					p_q <= p_q + NW'(1);
				end
			end
			SV_PASS: begin
				j_q <= j_q + NW'(1);
				m_q <= m_nxt;
				c_q <= c_nxt;
				if (pass_last && !p_at_max) begin
					p_q <= p_q + NW'(1);
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign built = built_q;

endmodule

>>> hdl/tms_sum_unit.sv
// Quotient walker and multiply-accumulate pipeline for the two divisor sums.
module tms_sum_unit import tms_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   n,
	input  tbl_word_t       rd_data,
	output ram_rd_t         rd,
	output logic            done,
	output logic [CP_W-1:0] coprime,
	output logic [GS_W-1:0] gsum
);

	localparam int unsigned RW    = NW + 1;
	localparam int unsigned SQ_W  = 2 * NW;
	localparam int unsigned PRD_W = SQ_W + PHI_W;

	logic             run_q;
	logic             walk_q;
	logic [NW-1:0]    k_q;
	logic [NW-1:0]    q_q;
	logic [RW-1:0]    r_q;
	logic             emit;

	logic             vld_s1, vld_s2, vld_s3;
	logic [NW-1:0]    q_s1;
	logic [SQ_W-1:0]  sq_s2;
	logic [PHI_W-1:0] phi_s2;
	logic [1:0]       mu_s2;
	logic [GS_W-1:0]  prod_s3;
	logic [CP_W-1:0]  cp_q;
	logic [GS_W-1:0]  gs_q;

	logic [SQ_W-1:0]  sq_full;
	logic [PRD_W-1:0] prod_full;

	// (q, r) with n = q*k + r is valid for k while r is non-negative
	assign emit    = walk_q && !r_q[RW-1];
	assign rd.en   = emit;
	assign rd.addr = k_q;

	assign sq_full   = SQ_W'(q_s1) * SQ_W'(q_s1);
	assign prod_full = PRD_W'(sq_s2) * PRD_W'(phi_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			walk_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= emit;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (start) begin
				run_q  <= 1'b1;
				walk_q <= (n != '0);
			end else begin
				if (done) begin
					run_q <= 1'b0;
				end
				if (emit && (k_q == n)) begin
					walk_q <= 1'b0;
				end
			end
		end
	end

	// walker: advance k on emit, otherwise step q down one and fix the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			k_q <= NW'(1);
			q_q <= n;
			r_q <= '0;
		end else if (walk_q) begin
			if (emit) begin
				if (k_q != n) begin
					k_q <= k_q + NW'(1);
					r_q <= r_q - {1'b0, q_q};
				end
			end else begin
				q_q <= q_q - NW'(1);
				r_q <= r_q + {1'b0, k_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		q_s1    <= q_q;
		sq_s2   <= sq_full;
		phi_s2  <= rd_data.phi;
		mu_s2   <= rd_data.mu;
		prod_s3 <= GS_W'(prod_full);
		if (start) begin
			cp_q <= '0;
			gs_q <= '0;
		end else begin
			if (vld_s2) begin
				case (mu_s2)
					MU_POS:  cp_q <= cp_q + CP_W'(sq_s2);
					MU_NEG:  cp_q <= cp_q - CP_W'(sq_s2);
					default: cp_q <= cp_q;
				endcase
			end
			if (vld_s3) begin
				gs_q <= gs_q + prod_s3;
			end
		end
	end

	assign done    = run_q && !walk_q && !vld_s1 && !vld_s2 && !vld_s3;
	assign coprime = cp_q;
	assign gsum    = gs_q;

endmodule

>>> hdl/totient_mobius_sieve_sums.sv
// Top level: coprime-pair count and gcd sum over [1,n]^2 from sieved phi/mu tables.
//
// channel   ports                           handshake
// -------   -----------------------------   -----------------------------------
// request   query_n                         taken on start && !busy
// result    coprime_pairs, gcd_sum          one cycle, marked by done
//
// First request after reset builds the tables: MAX_N+1 init writes, a read
// and a check per scanned value and one write per multiple of each prime.
// Each request then walks k = 1..n (n saturated to MAX_N): the walker issues
// one table read per k on the single RAM read port and steps q down between
// reads. busy stays high from a taken request until done.
// Reset clears the control state and the built flag; table contents restart
// from the sieve. done cannot be held off: capture results in that cycle.
module totient_mobius_sieve_sums import tms_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [QW-1:0]   query_n,
	output logic            busy,
	output logic            done,
	output logic [CP_W-1:0] coprime_pairs,
	output logic [GS_W-1:0] gcd_sum
);

	top_state_t      state_q, state_d;
	logic [NW-1:0]   n_q;
	logic            done_q;
	logic [CP_W-1:0] cp_out_q;
	logic [GS_W-1:0] gs_out_q;

	logic            accept;
	logic [NW-1:0]   n_sat;

	ram_rd_t         sv_rd, su_rd, ram_rd;
	ram_wr_t         ram_wr;
	tbl_word_t       ram_data;
	logic            sv_go;
	logic            sv_built;
	logic            su_start;
	logic            su_done;
	logic [CP_W-1:0] su_cp;
	logic [GS_W-1:0] su_gs;

	assign accept = start && !busy;

	// clamp the query to the table range
	always_comb begin
		if (32'(query_n) > 32'(MAX_N)) begin
			n_sat = NW'(MAX_N);
		end else begin
			n_sat = NW'(query_n);
		end
	end

	// the sieve owns the read port until the tables are built
	assign ram_rd = sv_built ? su_rd : sv_rd;

	tms_table_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (ram_rd),
		.wr      (ram_wr),
		.rd_data (ram_data)
	);

	tms_sieve u_sieve (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (sv_go),
		.rd_data (ram_data),
		.rd      (sv_rd),
		.wr      (ram_wr),
		.built   (sv_built)
	);

	tms_sum_unit u_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (su_start),
		.n       (n_q),
		.rd_data (ram_data),
		.rd      (su_rd),
		.done    (su_done),
		.coprime (su_cp),
		.gsum    (su_gs)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE: begin
				if (accept) begin
					state_d = sv_built ? TS_LAUNCH : TS_BUILD;
				end
			end
			TS_BUILD: begin
				if (sv_built) begin
					state_d = TS_LAUNCH;
				end
			end
			TS_LAUNCH: begin
				state_d = TS_SUM;
			end
			TS_SUM: begin
				if (su_done) begin
					state_d = TS_IDLE;
				end
			end
			default: begin
				state_d = TS_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		busy     = (state_q != TS_IDLE);
		sv_go    = (state_q == TS_BUILD);
		su_start = (state_q == TS_LAUNCH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == TS_SUM) && su_done;
		end
	end

	// hold the request and capture the sums for the result strobe
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n_sat;
		end
		if ((state_q == TS_SUM) && su_done) begin
			cp_out_q <= su_cp;
			gs_out_q <= su_gs;
		end
	end

	assign done          = done_q;
	assign coprime_pairs = cp_out_q;
	assign gcd_sum       = gs_out_q;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_no_write_while_summing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TS_SUM) |-> !ram_wr.en)
		else $error("table write during summation");
`endif

endmodule

>>> bench/tb_totient_mobius_sieve_sums.sv
// Self-checking testbench for the totient/Moebius sieve sums block.
`timescale 1ns / 100ps

import tms_pkg::*;

// Scoreboard: keeps its own sieve tables, predicts both sums per request and
// compares each result against the oldest prediction still waiting.
class sums_scoreboard;

	typedef struct {
		logic [QW-1:0]   query;
		logic [CP_W-1:0] coprime;
		logic [GS_W-1:0] gsum;
	} pair_sums_t;

	int unsigned phi_tbl [0:MAX_N];
	logic [1:0]  mu_tbl [0:MAX_N];
	bit          prime_tbl [0:MAX_N];
	bit          tables_ready;
	pair_sums_t  expected_sums [$];
	int          errors;

	function new();
		tables_ready = 1'b0;
		errors = 0;
	endfunction

	// Standard sieve: strip the 1/p share of phi and flip or clear mu for
	// every multiple of each prime.
	function void build_tables();
		int unsigned p, m;
		phi_tbl[0] = 0;
		mu_tbl[0] = MU_ZERO;
		prime_tbl[0] = 1'b0;
		phi_tbl[1] = 1;
		mu_tbl[1] = MU_POS;
		prime_tbl[1] = 1'b0;
		for (m = 2; m <= MAX_N; m++) begin
			phi_tbl[m] = m;
			mu_tbl[m] = MU_POS;
			prime_tbl[m] = 1'b1;
		end
		for (p = 2; p <= MAX_N; p++) begin
			if (!prime_tbl[p])
				continue;
			for (m = p; m <= MAX_N; m += p) begin
				if (m != p)
					prime_tbl[m] = 1'b0;
				phi_tbl[m] -= phi_tbl[m] / p;
				if ((m / p) % p == 0)
					mu_tbl[m] = MU_ZERO;
				else if (mu_tbl[m] == MU_POS)
					mu_tbl[m] = MU_NEG;
				else if (mu_tbl[m] == MU_NEG)
					mu_tbl[m] = MU_POS;
			end
		end
		tables_ready = 1'b1;
	endfunction

	// Both sums in 64-bit wrapping arithmetic, cut to the port widths.
	function pair_sums_t pair_sums(logic [QW-1:0] n_in);
		longint unsigned n, k, q, sq, cp, gs;
		pair_sums_t r;
		if (!tables_ready)
			build_tables();
		n = n_in;
		if (n > MAX_N)
			n = MAX_N;
		cp = 0;
		gs = 0;
		for (k = 1; k <= n; k++) begin
			q = n / k;
			sq = q * q;
			if (mu_tbl[k] == MU_POS)
				cp += sq;
			else if (mu_tbl[k] == MU_NEG)
				cp -= sq;
			gs += sq * longint'(phi_tbl[k]);
		end
		r.query = n_in;
		r.coprime = cp[CP_W-1:0];
		r.gsum = gs[GS_W-1:0];
		return r;
	endfunction

	function void flag(string msg);
		errors++;
		if (errors <= 10)
			$display("MISMATCH: %s", msg);
	endfunction

	function void note_query(logic [QW-1:0] n);
		expected_sums.push_back(pair_sums(n));
	endfunction

	function void check_result(logic [CP_W-1:0] cp, logic [GS_W-1:0] gs);
		pair_sums_t want;
		if (expected_sums.size() == 0) begin
			flag($sformatf("result with no request pending: coprime_pairs=%0d gcd_sum=%0d",
				cp, gs));
			return;
		end
		want = expected_sums.pop_front();
		if (cp !== want.coprime)
			flag($sformatf("n=%0d coprime_pairs expected %0d got %0d",
				want.query, want.coprime, cp));
		if (gs !== want.gsum)
			flag($sformatf("n=%0d gcd_sum expected %0d got %0d",
				want.query, want.gsum, gs));
	endfunction

	function int pending();
		return expected_sums.size();
	endfunction

endclass

module tb_totient_mobius_sieve_sums;

	// Budget for the slowest correct run of this stimulus: the sieve, two
	// saturated requests and some 120 more with n at most 8191, plus sender
	// gaps, with a wide margin on top.
	localparam int CYCLE_LIMIT = 10_000_000;
	// Requests per random phase.
	localparam int PHASE_ITEMS = 25;

	logic            clk;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic [QW-1:0]   query_n = '0;
	logic            busy;
	logic            done;
	logic [CP_W-1:0] coprime_pairs;
	logic [GS_W-1:0] gcd_sum;

	sums_scoreboard board = new();
	int             idle_pct = 0;
	int             cycle_count = 0;

	totient_mobius_sieve_sums dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.query_n       (query_n),
		.busy          (busy),
		.done          (done),
		.coprime_pairs (coprime_pairs),
		.gcd_sum       (gcd_sum)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung block or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Capture each result in its single done cycle; values read here are the
	// ones present before this edge.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(coprime_pairs, gcd_sum);
	end

	// Issue one request. Hold start low for a random gap first, then keep it
	// high until an edge sees busy low, which is when the request is taken.
	task automatic send_query(input logic [QW-1:0] n);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		query_n <= n;
		do
			@(posedge clk);
		while (busy);
		board.note_query(n);
	endtask

	// Drop start and hold off until every outstanding result is back.
	task automatic wait_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
	endtask

	// Mostly short ranges keep the walk cheap; some reach into the thousands.
	function automatic logic [QW-1:0] random_query();
		if ($urandom_range(99) < 85)
			return QW'($urandom_range(1000));
		return QW'($urandom_range(8191, 1001));
	endfunction

	initial begin
		logic [QW-1:0] directed_q [$];
		int            phase_idle [4];
		// Zero query, the smallest ranges, square-full and square-free values,
		// a prime, powers of two, MAX_N itself and an all-ones saturated query.
		directed_q = '{0, 1, 2, 3, 4, 5, 6, 8, 9, 12, 30, 36, 97, 210, 255,
			1000, 1024, 4095, 131072, 262143, 7, 0};
		// Phases: no idling, sender mostly idle, sender lightly idle, no idling.
		phase_idle = '{0, 84, 12, 0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part; the first request also triggers the table build.
		foreach (directed_q[i])
			send_query(directed_q[i]);
		wait_idle();

		// Random phases, each followed by a full drain.
		foreach (phase_idle[ph]) begin
			idle_pct = phase_idle[ph];
			repeat (PHASE_ITEMS)
				send_query(random_query());
			wait_idle();
		end

		// Let any stray late strobe show up before the verdict.
		repeat (16) @(posedge clk);
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
